### rtl/core/lwpe_pkg.sv
// Package for the LED wipe/pulse engine: field widths, register indexes,
// input kind codes and the saturating channel add. No dependencies.
package lwpe_pkg;

  localparam int CH_W     = 8;   // one color channel
  localparam int PIX_W    = 24;  // packed RGB pixel
  localparam int IDX_W    = 5;   // emitted pixel index
  localparam int POS_W    = 6;   // wipe position and stream counter
  localparam int STEP_W   = 8;
  localparam int LEN_W    = 7;
  localparam int OFF_W    = 8;   // signed brightness offset
  localparam int CALC_W   = 10;  // signed width for offset and channel sums
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd32;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_STEP   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // Input item kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic signed [CALC_W-1:0] CH_MAX = 10'sd255;

  // Add a signed offset to one channel, clamp to 0..255
  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] ch,
                                               input logic signed [OFF_W-1:0] off);
    logic signed [CALC_W-1:0] sum;
    sum = $signed({2'b00, ch}) + $signed({{2{off[OFF_W-1]}}, off});
    if (sum < 0) begin
      return '0;
    end else if (sum > CH_MAX) begin
      return '1;
    end
    return sum[CH_W-1:0];
  endfunction

endpackage

### rtl/core/lwpe_if.sv
// Valid/ready channel interfaces for the LED wipe/pulse engine.
// Depends on lwpe_pkg for field widths.
interface lwpe_cmd_if import lwpe_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0] new_red;
  logic [CH_W-1:0] new_green;
  logic [CH_W-1:0] new_blue;

  modport source (output valid, kind, new_red, new_green, new_blue, input ready);
  modport sink   (input valid, kind, new_red, new_green, new_blue, output ready);
endinterface

interface lwpe_pix_if import lwpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic             last_pixel;

  modport source (output valid, pixel_index, out_red, out_green, out_blue, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, out_red, out_green, out_blue, last_pixel,
                  output ready);
endinterface

### rtl/core/lwpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lwpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/led_wipe_pulse_engine.sv
// LED wipe/pulse engine top level. Depends on lwpe_pkg, lwpe_if and lwpe_ram.
//
// The engine holds a strip of STRIP_LEN RGB pixels in a RAM, a base color, a
// wipe position and a triangle-wave brightness offset. A set-color item stores
// the base color and restarts the wipe; it produces no pixels. A tick item
// writes the base color into the next pixel (while the wipe runs) and moves
// the offset by the step size, reversing at +/- the fold length. If either
// changed, a frame of STRIP_LEN pixels follows in index order, each channel
// offset with saturation at 0 and 255 (no offset when the step size is zero);
// the stored pixels are left untouched. A tick is accepted and updates the
// state first; then one saturating-add per channel handles one pixel per cycle
// while the output does not stall, behind the RAM's registered read, and the
// last read drains into the output register. cmd.ready is high only between
// frames; the last pixel may still wait in the output register while the next
// item is taken. Pixels never written read as zero through per-entry valid bits.
// Registers: step size at byte 0, fold length at byte 4 (reset 32).
module led_wipe_pulse_engine
  import lwpe_pkg::*;
#(
  parameter int STRIP_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  lwpe_cmd_if.sink          cmd,
  lwpe_pix_if.source        pix,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int ADDR_W = (STRIP_LEN > 1) ? $clog2(STRIP_LEN) : 1;
  localparam logic [POS_W-1:0] LED_END  = POS_W'(STRIP_LEN);
  localparam logic [POS_W-1:0] LED_LAST = POS_W'(STRIP_LEN - 1);

  // Sequencer state
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic state;

  // Configuration
  logic [STEP_W-1:0] step_size;
  logic [LEN_W-1:0]  fold_len;

  // Engine state
  logic [PIX_W-1:0]        base_color;
  logic [POS_W-1:0]        wipe_position;
  logic signed [OFF_W-1:0] bright_off;
  logic                    pulse_rising;
  logic [STRIP_LEN-1:0]    written;

  // Frame streaming
  logic signed [OFF_W-1:0] apply_off;
  logic [POS_W-1:0]        rd_idx;
  logic                    d_valid;
  logic [POS_W-1:0]        d_idx;
  logic                    d_written;
  logic [PIX_W-1:0]        rdata;

  // Output register
  logic             out_valid;
  logic [IDX_W-1:0] o_idx;
  logic [CH_W-1:0]  o_red;
  logic [CH_W-1:0]  o_green;
  logic [CH_W-1:0]  o_blue;
  logic             o_last;

  logic cmd_fire;
  logic cfg_write;
  logic wipe_active;
  logic out_free;
  logic rd_more;
  logic ram_we;
  logic ram_re;
  logic [PIX_W-1:0] px;

  logic signed [CALC_W-1:0] len_s;
  logic signed [CALC_W-1:0] off_sum;
  logic signed [OFF_W-1:0]  bright_off_next;
  logic                     pulse_rising_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_LENGTH) ? APB_DW'(fold_len) : APB_DW'(step_size);

  assign cmd.ready   = (state == ST_IDLE);
  assign cmd_fire    = cmd.valid && cmd.ready;
  assign wipe_active = (wipe_position < LED_END);

  // Triangle step: full-width sum, then fold back at +/- the fold length
  assign len_s   = $signed({3'b000, fold_len});
  assign off_sum = pulse_rising
                 ? $signed({{2{bright_off[OFF_W-1]}}, bright_off})
                   + $signed({2'b00, step_size})
                 : $signed({{2{bright_off[OFF_W-1]}}, bright_off})
                   - $signed({2'b00, step_size});

  always_comb begin
    bright_off_next   = off_sum[OFF_W-1:0];
    pulse_rising_next = pulse_rising;
    if (off_sum >= len_s) begin
      bright_off_next   = OFF_W'(len_s - 10'sd1);
      pulse_rising_next = 1'b0;
    end else if (off_sum <= -len_s) begin
      bright_off_next   = OFF_W'(10'sd1 - len_s);
      pulse_rising_next = 1'b1;
    end
  end

  // Output stage frees when empty or its transfer completes this cycle
  assign out_free = !out_valid || pix.ready;
  assign rd_more  = (rd_idx < LED_END);
  assign ram_we   = cmd_fire && (cmd.kind == KIND_TICK) && wipe_active;
  assign ram_re   = (state == ST_STREAM) && out_free && rd_more;
  assign px       = d_written ? rdata : '0;

  lwpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STRIP_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wipe_position[ADDR_W-1:0]),
    .wdata (base_color),
    .re    (ram_re),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step_size     <= '0;
      fold_len      <= LEN_RESET;
      base_color    <= '0;
      wipe_position <= LED_END;
      bright_off    <= '0;
      pulse_rising  <= 1'b1;
      written       <= '0;
      rd_idx        <= '0;
      d_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          REG_STEP:   step_size <= pwdata[STEP_W-1:0];
          REG_LENGTH: fold_len  <= pwdata[LEN_W-1:0];
          default:    ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            if (cmd.kind == KIND_SET) begin
              base_color    <= {cmd.new_red, cmd.new_green, cmd.new_blue};
              wipe_position <= '0;
            end else begin
              // Advance the wipe and the pulse, then stream if anything moved
              if (wipe_active) begin
                written[wipe_position[ADDR_W-1:0]] <= 1'b1;
                wipe_position <= wipe_position + POS_W'(1);
              end
              if (step_size != '0) begin
                bright_off   <= bright_off_next;
                pulse_rising <= pulse_rising_next;
              end
              if (wipe_active || (step_size != '0)) begin
                state  <= ST_STREAM;
                rd_idx <= '0;
              end
            end
          end
        end
        ST_STREAM: begin
          if (out_free) begin
            if (rd_more) begin
              rd_idx  <= rd_idx + POS_W'(1);
              d_valid <= 1'b1;
            end else begin
              // Last pixel moves to the output register this cycle
              d_valid <= 1'b0;
              state   <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_free) begin
        out_valid <= d_valid;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire && (cmd.kind == KIND_TICK)) begin
      apply_off <= (step_size != '0) ? bright_off_next : '0;
    end
    if (ram_re) begin
      d_idx     <= rd_idx;
      d_written <= written[rd_idx[ADDR_W-1:0]];
    end
    if (out_free && d_valid) begin
      o_idx   <= d_idx[IDX_W-1:0];
      o_red   <= sat_add(px[23:16], apply_off);
      o_green <= sat_add(px[15:8], apply_off);
      o_blue  <= sat_add(px[7:0], apply_off);
      o_last  <= (d_idx == LED_LAST);
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_index = o_idx;
  assign pix.out_red     = o_red;
  assign pix.out_green   = o_green;
  assign pix.out_blue    = o_blue;
  assign pix.last_pixel  = o_last;

  // Pending read data exists only inside a frame
  a_dvalid_in_stream: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (state == ST_STREAM))
    else $error("read stage valid outside a frame");

  // Stream counter never runs past the strip
  a_rd_idx_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= LED_END)
    else $error("stream counter beyond LED count");

  // A tick with the wipe running always starts a frame
  a_tick_starts_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (cmd.kind == KIND_TICK) && wipe_active) |=> (state == ST_STREAM))
    else $error("tick with wipe running did not start a frame");

  // The offset stays within +/-126 after any update
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (bright_off != -8'sd128) && (bright_off != 8'sd127))
    else $error("pulse offset out of range");

endmodule

### bench/led_wipe_pulse_checker.sv
// Pixel stream checker for the LED wipe/pulse engine: watches the command,
// pixel and register ports, predicts every frame and compares it pixel by pixel.
// Depends on lwpe_pkg and the lwpe_cmd_if / lwpe_pix_if interfaces.
module led_wipe_pulse_checker
  import lwpe_pkg::*;
#(
  parameter int STRIP_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  lwpe_cmd_if               cmd,
  lwpe_pix_if               pix,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } strip_pixel_t;

  logic [PIX_W-1:0]  strip [STRIP_LEN];
  logic [PIX_W-1:0]  base_rgb;
  int                wipe_at;
  int                glow;
  bit                glow_up;
  logic [STEP_W-1:0] glow_step;
  logic [LEN_W-1:0]  glow_len;
  strip_pixel_t      due_pixels [$];
  int                errs = 0;

  function automatic logic [CH_W-1:0] brighten(input logic [CH_W-1:0] ch, input int off);
    int v;
    v = int'(ch) + off;
    if (v < 0) return '0;
    if (v > 255) return '1;
    return CH_W'(v);
  endfunction

  // Advance the strip model by one command and queue the frame it causes.
  function automatic void apply_cmd(input logic kind, input logic [CH_W-1:0] r,
                                    input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    bit           changed;
    int           applied;
    int           nxt;
    strip_pixel_t px;
    if (kind == KIND_SET) begin
      base_rgb = {r, g, b};
      wipe_at = 0;
      return;
    end
    changed = 0;
    applied = 0;
    if (wipe_at < STRIP_LEN) begin
      strip[wipe_at] = base_rgb;
      wipe_at++;
      changed = 1;
    end
    if (glow_step != 0) begin
      nxt = glow_up ? glow + int'(glow_step) : glow - int'(glow_step);
      if (nxt >= int'(glow_len)) begin
        glow_up = 0;
        nxt = int'(glow_len) - 1;
      end else if (nxt <= -int'(glow_len)) begin
        glow_up = 1;
        nxt = 1 - int'(glow_len);
      end
      glow = nxt;
      applied = nxt;
      changed = 1;
    end
    if (!changed) return;
    for (int i = 0; i < STRIP_LEN; i++) begin
      px.idx   = IDX_W'(i);
      px.red   = brighten(strip[i][23:16], applied);
      px.green = brighten(strip[i][15:8], applied);
      px.blue  = brighten(strip[i][7:0], applied);
      px.last  = (i == STRIP_LEN - 1);
      due_pixels.push_back(px);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    strip_pixel_t want;
    if (rst) begin
      foreach (strip[i]) strip[i] = '0;
      base_rgb = '0;
      wipe_at = STRIP_LEN;
      glow = 0;
      glow_up = 1;
      glow_step = '0;
      glow_len = LEN_RESET;
      due_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LENGTH) glow_len = pwdata[LEN_W-1:0];
        else glow_step = pwdata[STEP_W-1:0];
      end
      // An old frame can finish in the cycle a new command is taken.
      if (pix.valid && pix.ready) begin
        if (due_pixels.size() == 0) begin
          errs++;
          $display("%0t: unexpected pixel, expected none, actual index %0d rgb %h%h%h",
                   $time, pix.pixel_index, pix.out_red, pix.out_green, pix.out_blue);
        end else begin
          want = due_pixels.pop_front();
          check_field("pixel_index", int'(want.idx), int'(pix.pixel_index));
          check_field("out_red", int'(want.red), int'(pix.out_red));
          check_field("out_green", int'(want.green), int'(pix.out_green));
          check_field("out_blue", int'(want.blue), int'(pix.out_blue));
          check_field("last_pixel", int'(want.last), int'(pix.last_pixel));
        end
      end
      if (cmd.valid && cmd.ready)
        apply_cmd(cmd.kind, cmd.new_red, cmd.new_green, cmd.new_blue);
    end
    pending <= due_pixels.size();
    fail_count <= errs;
  end

endmodule

### bench/led_wipe_pulse_engine_test.sv
// Top of the LED wipe/pulse engine bench: clock, reset, command and register
// stimulus, output back-pressure and the verdict. Depends on lwpe_pkg, the
// channel interfaces, led_wipe_pulse_engine and led_wipe_pulse_checker.
module led_wipe_pulse_engine_test
  import lwpe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STRIP_LEN    = 32;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 45;
  localparam int CALM_PHASE   = 5;
  localparam int DRAIN_CYCLES = STRIP_LEN + 8;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [APB_AW-1:0] ADDR_STEP   = {REG_STEP, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_LENGTH = {REG_LENGTH, 2'b00};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  bit                calm;
  int                fail_count;
  int                pending_pixels;
  int                quiet_cycles;

  lwpe_cmd_if cmd ();
  lwpe_pix_if pix ();

  led_wipe_pulse_engine #(.STRIP_LEN(STRIP_LEN)) uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .pix     (pix),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  led_wipe_pulse_checker #(.STRIP_LEN(STRIP_LEN)) pix_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .pix        (pix),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending_pixels)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the pixel stream about a quarter of the time, except in the calm phase.
  always @(posedge clk) begin
    pix.ready <= calm || ($urandom_range(99) >= 26);
  end

  // Watchdog: any transfer or register access restarts the count of dead cycles.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (pix.valid && pix.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL led_wipe_pulse_engine");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command and hold it until the transfer; idle first at random.
  task automatic send_item(input logic kind, input logic [CH_W-1:0] r,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    while (!calm && $urandom_range(99) < 26) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.kind      <= kind;
    cmd.new_red   <= r;
    cmd.new_green <= g;
    cmd.new_blue  <= b;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // Drop valid, let every predicted pixel drain, then give the engine time
  // to finish any command that produced no frame.
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then psel and penable drop so writes can follow back to back.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [STEP_W-1:0] step_val;
    logic [LEN_W-1:0]  len_val;
    logic              kind;

    rst           <= 1'b1;
    calm          <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cmd.valid     <= 1'b0;
    cmd.kind      <= KIND_TICK;
    cmd.new_red   <= '0;
    cmd.new_green <= '0;
    cmd.new_blue  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: pulse off, wipe already finished, so a tick changes nothing.
    send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);
    // Restart the wipe in white; each tick paints one more pixel with no offset.
    send_item(KIND_SET, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_item(KIND_SET, 8'hAA, 8'h55, 8'h0F);
    send_item(KIND_TICK, 8'hFF, 8'hFF, 8'hFF);

    // Largest step against the longest pulse: the offset clamps at both ends
    // and the channels saturate at full and at zero.
    wait_idle();
    apb_write(ADDR_STEP, 32'd255);
    apb_write(ADDR_LENGTH, 32'd127);
    repeat (3) send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_item(KIND_SET, 8'h00, 8'h00, 8'h00);
    send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

    // Pulse off while the wipe runs: the stale offset stays but is not applied.
    wait_idle();
    apb_write(ADDR_STEP, 32'd0);
    send_item(KIND_SET, 8'h80, 8'h7F, 8'h01);
    send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

    // Zero pulse length: the offset flips between -1 and +1.
    wait_idle();
    apb_write(ADDR_LENGTH, 32'd0);
    apb_write(ADDR_STEP, 32'd1);
    repeat (3) send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

    // Shortest nonzero length with a step past it.
    wait_idle();
    apb_write(ADDR_LENGTH, 32'd1);
    apb_write(ADDR_STEP, 32'd3);
    repeat (2) send_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

    // Random phases: new pulse settings each phase, mostly ticks with a
    // color restart now and then so the wipe keeps running.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(5))
        0:       step_val = '0;
        1:       step_val = 8'd255;
        2:       step_val = STEP_W'($urandom_range(1, 255));
        default: step_val = STEP_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(5))
        0:       len_val = 7'd127;
        1:       len_val = LEN_W'($urandom_range(0, 2));
        default: len_val = LEN_W'($urandom_range(1, 127));
      endcase
      apb_write(ADDR_STEP, APB_DW'(step_val));
      apb_write(ADDR_LENGTH, APB_DW'(len_val));
      calm <= (ph == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(99) < 15) ? KIND_SET : KIND_TICK;
        send_item(kind, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
      end
    end

    // Drain the last frames, then judge.
    wait_idle();
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("PASS led_wipe_pulse_engine");
    end else begin
      $display("FAIL led_wipe_pulse_engine");
    end
    $finish;
  end

endmodule
